[design/handle_pool_allocator_macros.svh]
// Assertion macros for the handle pool allocator.
// Included by the top level; needs a clk and an active-low rst_n in scope.
`ifndef HANDLE_POOL_ALLOCATOR_MACROS_SVH
`define HANDLE_POOL_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define HPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle pool allocator check failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define HPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle pool allocator check failed");
`else
`define HPA_ASSERT_IMP(label, ante, cons)
`define HPA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/hpa_pkg.sv]
// Package for the handle pool allocator: transaction structs, codes and sizes.
// No dependencies; imported by hpa_held_map and handle_pool_allocator.
`default_nettype none

package hpa_pkg;

    localparam int HANDLE_W     = 6;
    localparam int HANDLE_SPACE = 64;
    localparam int COUNT_W      = HANDLE_W + 1;

    // Request opcodes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_TRY     = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Response status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NONE      = 2'd1;
    localparam logic [1:0] STAT_NOT_HELD  = 2'd2;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [HANDLE_W-1:0] handle_in;
    } hpa_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [1:0]          status;
    } hpa_rsp_t;

    // Access bundle for the held bitmap.
    typedef struct packed {
        logic                rd_en;
        logic [HANDLE_W-1:0] rd_addr;
        logic                wr_en;
        logic [HANDLE_W-1:0] wr_addr;
        logic                wr_bit;
    } hpa_map_req_t;

endpackage

`default_nettype wire

[design/hpa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/hpa_held_map.sv]
// Held bitmap: one bit per handle in a RAM, with per-entry valid flops so that
// reset clears the whole map at once. Depends on hpa_pkg and hpa_ram.
`default_nettype none

module hpa_held_map (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hpa_pkg::hpa_map_req_t map_req,
    output logic                      held
);

    import hpa_pkg::*;

    logic [HANDLE_SPACE-1:0] valid_reg;
    logic [HANDLE_SPACE-1:0] valid_next;
    logic [HANDLE_W-1:0]     addr_reg;
    logic                    ram_q;

    hpa_ram #(
        .WIDTH (1),
        .DEPTH (HANDLE_SPACE)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_req.wr_en),
        .wr_addr (map_req.wr_addr),
        .wr_data (map_req.wr_bit),
        .rd_en   (map_req.rd_en),
        .rd_addr (map_req.rd_addr),
        .rd_data (ram_q)
    );

    // An entry becomes valid the first time it is written.
    always_comb
    begin
        valid_next = valid_reg;
        if (map_req.wr_en)
        begin
            valid_next[map_req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Keep the read address to pick the matching valid bit.
    always_ff @(posedge clk)
    begin
        if (map_req.rd_en)
        begin
            addr_reg <= map_req.rd_addr;
        end
    end

    // An entry never written reads as cleared.
    assign held = valid_reg[addr_reg] & ram_q;

endmodule

`default_nettype wire

[design/handle_pool_allocator.sv]
// Handle pool allocator: each request transaction on req_item (opcode and a
// handle to release) yields exactly one response transaction on rsp_item
// (granted handle and status).
// Allocate reuses the oldest released handle from a free FIFO, else issues a
// fresh handle until the pool is exhausted; try-allocate only reuses; release
// checks the held bitmap and queues the handle for reuse.
// On accept the block issues the reads of the free FIFO RAM and the held bitmap
// RAM; in the execute state it uses the registered read data, writes back and
// loads the response register and the registered rsp_valid. No new request is
// taken until the execute state is done.
// The response register frees the request side: a request may be accepted while
// a response still waits. If rsp_stall holds a response and the next one is
// ready, the block waits with req_stall high until the response is taken.
// Reset empties the FIFO, clears the held bitmap and the fresh counter at once;
// the block comes out of reset idle and ready to accept a request.
// Depends on hpa_pkg, hpa_ram, hpa_held_map and the assertion macro header.
`default_nettype none

`include "handle_pool_allocator_macros.svh"

module handle_pool_allocator #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire hpa_pkg::hpa_req_t req_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output hpa_pkg::hpa_rsp_t      rsp_item
);

    import hpa_pkg::*;

    // Handles are six bits wide, so at most HANDLE_SPACE of them exist.
    localparam int EffPool = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [HANDLE_W-1:0] head_reg, head_next;
    logic [HANDLE_W-1:0] tail_reg, tail_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  fresh_next_reg, fresh_next_next;
    logic                rsp_valid_reg, rsp_valid_next;
    hpa_rsp_t            rsp_item_reg, rsp_item_next;
    hpa_req_t            op_item_reg;

    logic                req_fire;
    logic                exec_fire;
    logic [HANDLE_W-1:0] fifo_q;
    logic                fifo_wr_en;
    logic                held;
    hpa_map_req_t        map_req;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign exec_fire = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);

    // Free FIFO storage, read at the head when a request is accepted.
    hpa_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (HANDLE_SPACE)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (fifo_wr_en),
        .wr_addr (tail_reg),
        .wr_data (op_item_reg.handle_in),
        .rd_en   (req_fire),
        .rd_addr (head_reg),
        .rd_data (fifo_q)
    );

    hpa_held_map u_held_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .map_req (map_req),
        .held    (held)
    );

    // Capture the request payload at accept.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_item_reg <= req_item;
        end
    end

    // Request evaluation and write-back.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        fresh_next_next = fresh_next_reg;
        rsp_item_next   = rsp_item_reg;
        fifo_wr_en      = 1'b0;

        map_req.rd_en   = req_fire;
        map_req.rd_addr = req_item.handle_in;
        map_req.wr_en   = 1'b0;
        map_req.wr_addr = op_item_reg.handle_in;
        map_req.wr_bit  = 1'b0;

        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next               = S_IDLE;
                    rsp_valid_next           = 1'b1;
                    rsp_item_next.handle_out = '0;
                    rsp_item_next.status     = STAT_NONE;
                    case (op_item_reg.opcode)
                        OP_ALLOC, OP_TRY:
                        begin
                            if (count_reg != '0)
                            begin
                                // Reuse the oldest released handle.
                                rsp_item_next.handle_out = fifo_q;
                                rsp_item_next.status     = STAT_OK;
                                head_next                = head_reg + 1'b1;
                                count_next               = count_reg - 1'b1;
                                map_req.wr_en            = 1'b1;
                                map_req.wr_addr          = fifo_q;
                                map_req.wr_bit           = 1'b1;
                            end
                            else if (op_item_reg.opcode == OP_TRY)
                            begin
                                rsp_item_next.status = STAT_NONE;
                            end
                            else if (fresh_next_reg < COUNT_W'(EffPool))
                            begin
                                // Issue a never-used handle.
                                rsp_item_next.handle_out = fresh_next_reg[HANDLE_W-1:0];
                                rsp_item_next.status     = STAT_OK;
                                fresh_next_next          = fresh_next_reg + 1'b1;
                                map_req.wr_en            = 1'b1;
                                map_req.wr_addr          = fresh_next_reg[HANDLE_W-1:0];
                                map_req.wr_bit           = 1'b1;
                            end
                            else
                            begin
                                rsp_item_next.status = STAT_EXHAUSTED;
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (!held)
                            begin
                                rsp_item_next.status = STAT_NOT_HELD;
                            end
                            else
                            begin
                                rsp_item_next.status = STAT_OK;
                                map_req.wr_en        = 1'b1;
                                map_req.wr_bit       = 1'b0;
                                // A full FIFO drops the push.
                                if (count_reg < COUNT_W'(HANDLE_SPACE))
                                begin
                                    fifo_wr_en = 1'b1;
                                    tail_next  = tail_reg + 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            rsp_item_next.status = STAT_NONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            fresh_next_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            fresh_next_reg <= fresh_next_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // The FIFO pointers and the fill count stay consistent.
    `HPA_ASSERT_IMP(a_fifo_ptrs, 1'b1, (tail_reg - head_reg) == count_reg[HANDLE_W-1:0])
    // The fill count never exceeds the handle space.
    `HPA_ASSERT_IMP(a_count_range, 1'b1, count_reg <= COUNT_W'(HANDLE_SPACE))
    // The fresh counter never passes the pool size.
    `HPA_ASSERT_IMP(a_fresh_range, 1'b1, fresh_next_reg <= COUNT_W'(EffPool))
    // An accepted request puts the block in the execute state in the following cycle.
    `HPA_ASSERT_NEXT(a_accept_exec, req_fire, state_reg == S_EXEC)

endmodule

`default_nettype wire
